// ----- rtl/core/i2cebm_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cebm_pkg
// Shared types and constants for the two-wire EEPROM byte master.
// ----------------------------------------------------------------------------
package i2cebm_pkg;

  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_TICKS      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_WAIT_TICKS = 2'd1;

  localparam logic [7:0]  PHASE_TICKS_RESET      = 8'd5;
  localparam logic [15:0] WRITE_WAIT_TICKS_RESET = 16'd12;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  localparam logic [3:0] DEVICE_CODE = 4'b1010;

  typedef struct packed {
    logic [1:0]  kind;
    logic [10:0] mem_address;
    logic [7:0]  write_data;
    logic        sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       nack_seen;
    logic       rejected;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  phase_ticks;
    logic [15:0] write_wait_ticks;
  } cfg_t;

endpackage

// ----- rtl/core/i2c_eeprom_byte_master.sv -----
// ----------------------------------------------------------------------------
// i2c_eeprom_byte_master
// Two-wire master for an 11-bit-addressed serial EEPROM, one item per tick.
// ----------------------------------------------------------------------------
// Each input item is one timing tick. It carries a command kind (tick only,
// read or write), the byte address, the write data and the sampled data line.
// Each accepted item yields exactly one result item with the clock and data
// line levels for that tick and the status: busy, done, last read byte,
// missing acknowledge and a rejected command.
// A command is taken only while idle; one that arrives during a transfer or
// the post-write programming wait is ignored and flagged as rejected.
// An item's result sits in the output register from the cycle after it is
// accepted. The block takes one item per cycle; input ready is high whenever
// the output register is empty or is being emptied in the same cycle, so a
// stalled receiver holds the result and stalls the input side after one item.
// The configuration channel is always ready and holds the ticks per bus
// phase and the write wait length; write it only while idle.
// Reset returns the sequencer to idle, clears the status and restores the
// configuration to five ticks per phase and a twelve-tick write wait.
// ----------------------------------------------------------------------------
module i2c_eeprom_byte_master
  import i2cebm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]            cfg_data
);

  cfg_t      cfg;
  out_item_t result;
  logic      in_accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_ticks      <= PHASE_TICKS_RESET;
      cfg.write_wait_ticks <= WRITE_WAIT_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_PHASE_TICKS) begin
        cfg.phase_ticks <= cfg_data[7:0];
      end else if (cfg_index == CFG_WRITE_WAIT_TICKS) begin
        cfg.write_wait_ticks <= cfg_data;
      end
    end
  end

  i2cebm_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .step_en (in_accept),
    .item    (in_data),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data <= result;
    end
  end

endmodule

// ----- rtl/core/i2cebm_seq.sv -----
// ----------------------------------------------------------------------------
// i2cebm_seq
// Bus sequencer: advances the transfer by one tick per accepted item and
// forms that tick's line levels and status.
// ----------------------------------------------------------------------------
module i2cebm_seq
  import i2cebm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step_en,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_DEV,
    ST_WORD,
    ST_DATA,
    ST_RESTART,
    ST_DEVRD,
    ST_READ,
    ST_STOP,
    ST_WAIT
  } step_t;

  step_t       step, step_next, cur_step;
  logic [7:0]  phase_counter, phase_counter_next;
  logic [15:0] wait_counter, wait_counter_next;
  logic [3:0]  bit_counter, bit_counter_next;
  logic        half_slot, half_slot_next;
  logic [7:0]  shift_register, shift_register_next;
  logic [10:0] held_address, held_address_next;
  logic [7:0]  held_data, held_data_next;
  logic        is_read, is_read_next;
  logic [7:0]  read_byte, read_byte_next;
  logic        nack_flag, nack_flag_next;

  logic        cmd;
  logic        byte_out;
  logic        last_slot;
  logic [7:0]  pt;
  logic [7:0]  dev_byte;
  logic [1:0]  slot;
  logic        scl, sda, busy, done, rej;

  assign cmd      = (item.kind == KIND_READ) || (item.kind == KIND_WRITE);
  assign pt       = (cfg.phase_ticks == 8'd0) ? 8'd1 : cfg.phase_ticks;
  assign dev_byte = {DEVICE_CODE, held_address_next[10:8], 1'b0};

  always_comb begin
    step_next           = step;
    phase_counter_next  = phase_counter;
    wait_counter_next   = wait_counter;
    bit_counter_next    = bit_counter;
    half_slot_next      = half_slot;
    shift_register_next = shift_register;
    held_address_next   = held_address;
    held_data_next      = held_data;
    is_read_next        = is_read;
    read_byte_next      = read_byte;
    nack_flag_next      = nack_flag;
    scl       = 1'b1;
    sda       = 1'b1;
    busy      = 1'b0;
    done      = 1'b0;
    rej       = 1'b0;
    byte_out  = 1'b0;
    last_slot = 1'b0;
    slot      = 2'd0;

    if (step == ST_IDLE) begin
      if (cmd) begin
        held_address_next  = item.mem_address;
        held_data_next     = item.write_data;
        is_read_next       = (item.kind == KIND_READ);
        nack_flag_next     = 1'b0;
        step_next          = ST_START;
        bit_counter_next   = 4'd0;
        half_slot_next     = 1'b0;
        phase_counter_next = 8'd0;
      end
    end else if (cmd) begin
      rej = 1'b1;
    end

    cur_step = step_next;
    byte_out = (cur_step == ST_DEV) || (cur_step == ST_WORD) ||
               (cur_step == ST_DATA) || (cur_step == ST_DEVRD);
    slot     = {bit_counter_next[0], half_slot_next};

    if (cur_step == ST_WAIT) begin
      busy = 1'b1;
      if ({1'b0, wait_counter_next} + 17'd1 >= {1'b0, cfg.write_wait_ticks}) begin
        done              = 1'b1;
        wait_counter_next = 16'd0;
        step_next         = ST_IDLE;
      end else begin
        wait_counter_next = wait_counter_next + 16'd1;
      end
    end else if (cur_step != ST_IDLE) begin
      busy = 1'b1;

      unique case (cur_step) inside
        ST_START, ST_RESTART: begin
          scl = (slot != 2'd3) && !(cur_step == ST_RESTART && slot == 2'd0);
          sda = !slot[1];
        end
        ST_DEV, ST_WORD, ST_DATA, ST_DEVRD: begin
          if (!bit_counter_next[3]) begin
            scl = half_slot_next;
            sda = shift_register_next[3'd7 - bit_counter_next[2:0]];
          end else if (!half_slot_next) begin
            scl = 1'b0;
            sda = shift_register_next[0];
          end else begin
            scl = 1'b1;
            sda = 1'b1;
          end
        end
        ST_READ: begin
          scl = !half_slot_next;
          sda = 1'b1;
        end
        ST_STOP: begin
          scl = slot[1];
          sda = (slot == 2'd0) || (slot == 2'd3);
        end
        default: begin
          scl = 1'b1;
          sda = 1'b1;
        end
      endcase

      if ({1'b0, phase_counter_next} + 9'd1 < {1'b0, pt}) begin
        phase_counter_next = phase_counter_next + 8'd1;
      end else begin
        phase_counter_next = 8'd0;
        last_slot = half_slot_next && (
          ((cur_step == ST_START || cur_step == ST_RESTART || cur_step == ST_STOP) &&
           bit_counter_next == 4'd1) ||
          (byte_out && bit_counter_next == 4'd8) ||
          (cur_step == ST_READ && bit_counter_next == 4'd7));
        if (byte_out && bit_counter_next == 4'd8 && half_slot_next && item.sda_in) begin
          nack_flag_next = 1'b1;
        end
        if (cur_step == ST_READ && !half_slot_next) begin
          shift_register_next = {shift_register_next[6:0], item.sda_in};
        end
        if (half_slot_next) begin
          half_slot_next   = 1'b0;
          bit_counter_next = bit_counter_next + 4'd1;
        end else begin
          half_slot_next = 1'b1;
        end

        if (last_slot) begin
          bit_counter_next = 4'd0;
          half_slot_next   = 1'b0;
          unique case (cur_step)
            ST_START: begin
              step_next           = ST_DEV;
              shift_register_next = dev_byte;
            end
            ST_DEV: begin
              step_next           = ST_WORD;
              shift_register_next = held_address_next[7:0];
            end
            ST_WORD: begin
              if (is_read_next) begin
                step_next = ST_RESTART;
              end else begin
                step_next           = ST_DATA;
                shift_register_next = held_data_next;
              end
            end
            ST_DATA: begin
              step_next = ST_STOP;
            end
            ST_RESTART: begin
              step_next           = ST_DEVRD;
              shift_register_next = dev_byte | 8'h01;
            end
            ST_DEVRD: begin
              step_next           = ST_READ;
              shift_register_next = 8'd0;
            end
            ST_READ: begin
              step_next = ST_STOP;
            end
            ST_STOP: begin
              if (is_read_next) begin
                read_byte_next = shift_register_next;
                done           = 1'b1;
                step_next      = ST_IDLE;
              end else if (cfg.write_wait_ticks == 16'd0) begin
                done      = 1'b1;
                step_next = ST_IDLE;
              end else begin
                step_next         = ST_WAIT;
                wait_counter_next = 16'd0;
              end
            end
            default: begin
              step_next = cur_step;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step           <= ST_IDLE;
      phase_counter  <= 8'd0;
      wait_counter   <= 16'd0;
      bit_counter    <= 4'd0;
      half_slot      <= 1'b0;
      shift_register <= 8'd0;
      held_address   <= 11'd0;
      held_data      <= 8'd0;
      is_read        <= 1'b0;
      read_byte      <= 8'd0;
      nack_flag      <= 1'b0;
    end else if (step_en) begin
      step           <= step_next;
      phase_counter  <= phase_counter_next;
      wait_counter   <= wait_counter_next;
      bit_counter    <= bit_counter_next;
      half_slot      <= half_slot_next;
      shift_register <= shift_register_next;
      held_address   <= held_address_next;
      held_data      <= held_data_next;
      is_read        <= is_read_next;
      read_byte      <= read_byte_next;
      nack_flag      <= nack_flag_next;
    end
  end

  always_comb begin
    result.scl       = scl;
    result.sda_out   = sda;
    result.busy_res  = busy;
    result.done_res  = done;
    result.read_data = read_byte_next;
    result.nack_seen = nack_flag_next;
    result.rejected  = rej;
  end

endmodule
